@@ sv/n2kfe_pkg.sv @@
// ----------------------------------------------------------------------------
// n2kfe_pkg: shared types and constants of the frame encoder
// Field widths, register codes, reset values and the queue record format.
// ----------------------------------------------------------------------------
package n2kfe_pkg;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int PRIO_W    = 3;
  localparam int PGN_W     = 18;
  localparam int TS_W      = 32;
  localparam int LEN_W     = 8;
  localparam int CFG_IDX_W = 3;

  // framing constants
  localparam int MAX_DATA_LEN = 223;
  localparam int HDR_LEN_BIAS = 11;
  localparam int QUEUE_DEPTH  = 4;

  // header sequencer: DLE, STX, then body bytes up to the data length
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] HDR_BODY_IDX = 4'd2;
  localparam logic [IDX_W-1:0] HDR_LAST_IDX = 4'd14;

  // configuration register reset values
  localparam logic [BYTE_W-1:0] RST_COMMAND = 8'd147;
  localparam logic [BYTE_W-1:0] RST_DLE     = 8'd16;
  localparam logic [BYTE_W-1:0] RST_ESC     = 8'd27;
  localparam logic [BYTE_W-1:0] RST_STX     = 8'd2;
  localparam logic [BYTE_W-1:0] RST_ETX     = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMMAND = 3'd0,
    REG_DLE     = 3'd1,
    REG_ESC     = 3'd2,
    REG_STX     = 3'd3,
    REG_ETX     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] dle;
    logic [BYTE_W-1:0] esc;
    logic [BYTE_W-1:0] stx;
    logic [BYTE_W-1:0] etx;
  } cfg_t;

  // item classes handed from front to back
  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              close;     // frame closes after this item
    logic [PRIO_W-1:0] prio;
    logic [PGN_W-1:0]  pgn;
    logic [BYTE_W-1:0] destination;
    logic [BYTE_W-1:0] source;
    logic [TS_W-1:0]   timestamp;
    logic [LEN_W-1:0]  len;       // saturated data length
    logic [BYTE_W-1:0] data;
  } rec_t;

endpackage

@@ sv/n2kfe_if.sv @@
// ----------------------------------------------------------------------------
// n2kfe_if: input and output channel interfaces
// Valid/ready channels carrying one item or one stream byte per beat.
// ----------------------------------------------------------------------------
interface n2kfe_in_if
  import n2kfe_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [PRIO_W-1:0] priority_req;
  logic [PGN_W-1:0]  pgn;
  logic [BYTE_W-1:0] destination;
  logic [BYTE_W-1:0] source;
  logic [TS_W-1:0]   timestamp;
  logic [LEN_W-1:0]  data_len;
  logic [BYTE_W-1:0] data_byte;

  modport source_mp (
    output valid, action, priority_req, pgn, destination, source, timestamp,
           data_len, data_byte,
    input  ready
  );
  modport sink (
    input  valid, action, priority_req, pgn, destination, source, timestamp,
           data_len, data_byte,
    output ready
  );
endinterface

interface n2kfe_out_if
  import n2kfe_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;
  logic              frame_end;
  logic              error;

  modport source_mp (
    output valid, out_byte, last, frame_end, error,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last, frame_end, error,
    output ready
  );
endinterface

@@ sv/n2kfe_front.sv @@
// ----------------------------------------------------------------------------
// n2kfe_front: item intake and classification
// Tracks the open message and remaining data count, tags each beat as
// header, data or error and marks the item that closes the frame.
// ----------------------------------------------------------------------------
module n2kfe_front
  import n2kfe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  n2kfe_in_if.sink     in_ch,
  output logic         push_valid,
  input  logic         push_ready,
  output rec_t         push_rec
);

  logic             message_open;
  logic [LEN_W-1:0] bytes_remaining;
  logic [LEN_W-1:0] sat_len;
  logic             fire;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign fire        = in_ch.valid && push_ready;

  // clamp the announced length
  assign sat_len = (in_ch.data_len > LEN_W'(MAX_DATA_LEN)) ? LEN_W'(MAX_DATA_LEN)
                                                           : in_ch.data_len;

  // classify the beat
  always_comb begin
    push_rec.prio        = in_ch.priority_req;
    push_rec.pgn         = in_ch.pgn;
    push_rec.destination = in_ch.destination;
    push_rec.source      = in_ch.source;
    push_rec.timestamp   = in_ch.timestamp;
    push_rec.len         = sat_len;
    push_rec.data        = in_ch.data_byte;
    if (!in_ch.action) begin
      push_rec.kind  = KIND_HDR;
      push_rec.close = (sat_len == '0);
    end else if (!message_open) begin
      push_rec.kind  = KIND_ERR;
      push_rec.close = 1'b0;
    end else begin
      push_rec.kind  = KIND_DATA;
      push_rec.close = (bytes_remaining == LEN_W'(1));
    end
  end

  // message tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      message_open    <= 1'b0;
      bytes_remaining <= '0;
    end else if (fire) begin
      if (!in_ch.action) begin
        message_open    <= (sat_len != '0);
        bytes_remaining <= sat_len;
      end else if (message_open) begin
        message_open    <= (bytes_remaining != LEN_W'(1));
        bytes_remaining <= bytes_remaining - LEN_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // an open message always has data left to come
  a_open_count: assert property (@(posedge clk) disable iff (rst)
    message_open == (bytes_remaining != '0))
    else $error("open flag and remaining count disagree");
`endif

endmodule

@@ sv/n2kfe_queue.sv @@
// ----------------------------------------------------------------------------
// n2kfe_queue: record queue between front and back
// Small register FIFO so intake and byte emission stall independently.
// ----------------------------------------------------------------------------
module n2kfe_queue
  import n2kfe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  rec_t push_rec,
  output logic pop_valid,
  input  logic pop_ready,
  output rec_t pop_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_rec    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

@@ sv/n2kfe_back.sv @@
// ----------------------------------------------------------------------------
// n2kfe_back: frame byte sequencer
// Expands queued records into the escaped byte stream, keeps the running
// sum, appends checksum and DLE/ETX, and drives the output register.
// ----------------------------------------------------------------------------
module n2kfe_back
  import n2kfe_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  rec_t           pop_rec,
  n2kfe_out_if.source_mp out_ch
);

  typedef enum logic [2:0] {
    PH_HDR, PH_DATA, PH_CSUM, PH_DLE, PH_ETX, PH_ERR
  } phase_t;

  logic              busy;
  rec_t              rec;
  phase_t            phase;
  logic [IDX_W-1:0]  idx;
  logic              dup;
  logic [BYTE_W-1:0] running_sum;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              out_frame_end;
  logic              out_error;

  logic              load_out;
  logic              emit;
  logic              pop;
  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] hdr_byte;
  logic              is_body;
  logic              is_summed;
  logic              step_end;    // phase done after this byte
  logic              rec_end;     // record done after this byte
  logic              dup_need;
  logic              rec_done;
  logic              cur_frame_end;
  logic              cur_error;
  phase_t            phase_next;
  phase_t            start_phase;

  assign out_ch.valid     = out_valid;
  assign out_ch.out_byte  = out_byte;
  assign out_ch.last      = out_last;
  assign out_ch.frame_end = out_frame_end;
  assign out_ch.error     = out_error;

  assign load_out  = !out_valid || out_ch.ready;
  assign emit      = busy && load_out;

  // header byte order
  always_comb begin
    unique case (idx)
      4'd0:    hdr_byte = cfg.dle;
      4'd1:    hdr_byte = cfg.stx;
      4'd2:    hdr_byte = cfg.command;
      4'd3:    hdr_byte = rec.len + LEN_W'(HDR_LEN_BIAS);
      4'd4:    hdr_byte = BYTE_W'(rec.prio);
      4'd5:    hdr_byte = rec.pgn[7:0];
      4'd6:    hdr_byte = rec.pgn[15:8];
      4'd7:    hdr_byte = BYTE_W'(rec.pgn[PGN_W-1:16]);
      4'd8:    hdr_byte = rec.destination;
      4'd9:    hdr_byte = rec.source;
      4'd10:   hdr_byte = rec.timestamp[7:0];
      4'd11:   hdr_byte = rec.timestamp[15:8];
      4'd12:   hdr_byte = rec.timestamp[23:16];
      4'd13:   hdr_byte = rec.timestamp[31:24];
      4'd14:   hdr_byte = rec.len;
      default: hdr_byte = '0;
    endcase
  end

  // current byte and where the sequence goes next
  always_comb begin
    cur_byte      = '0;
    is_body       = 1'b0;
    is_summed     = 1'b0;
    step_end      = 1'b1;
    rec_end       = 1'b0;
    cur_frame_end = 1'b0;
    cur_error     = 1'b0;
    phase_next    = phase;
    unique case (phase)
      PH_HDR: begin
        cur_byte   = hdr_byte;
        is_body    = (idx >= HDR_BODY_IDX);
        is_summed  = is_body;
        step_end   = (idx == HDR_LAST_IDX);
        rec_end    = step_end && !rec.close;
        phase_next = PH_CSUM;
      end
      PH_DATA: begin
        cur_byte   = rec.data;
        is_body    = 1'b1;
        is_summed  = 1'b1;
        rec_end    = !rec.close;
        phase_next = PH_CSUM;
      end
      PH_CSUM: begin
        cur_byte   = ~running_sum + BYTE_W'(1);
        is_body    = 1'b1;
        phase_next = PH_DLE;
      end
      PH_DLE: begin
        cur_byte   = cfg.dle;
        phase_next = PH_ETX;
      end
      PH_ETX: begin
        cur_byte      = cfg.etx;
        rec_end       = 1'b1;
        cur_frame_end = 1'b1;
      end
      PH_ERR: begin
        rec_end   = 1'b1;
        cur_error = 1'b1;
      end
      default: begin
        rec_end = 1'b1;
      end
    endcase
  end

  // a special body byte goes out twice; the first copy holds the step
  assign dup_need = is_body && !dup && (cur_byte == cfg.dle || cur_byte == cfg.esc);
  assign rec_done = rec_end && !dup_need;
  assign pop_ready = !busy || (emit && rec_done);
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    unique case (pop_rec.kind)
      KIND_HDR:  start_phase = PH_HDR;
      KIND_DATA: start_phase = PH_DATA;
      default:   start_phase = PH_ERR;
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      phase       <= PH_ERR;
      idx         <= '0;
      dup         <= 1'b0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= emit;
      end
      if (emit) begin
        if (dup_need) begin
          dup <= 1'b1;
        end else begin
          dup <= 1'b0;
          if (phase == PH_HDR && idx == '0) begin
            running_sum <= '0;
          end else if (is_summed) begin
            running_sum <= running_sum + cur_byte;
          end
          if (phase == PH_HDR && !step_end) begin
            idx <= idx + IDX_W'(1);
          end else if (!rec_end) begin
            phase <= phase_next;
          end
        end
      end
      if (pop) begin
        busy  <= 1'b1;
        phase <= start_phase;
        idx   <= '0;
        dup   <= 1'b0;
      end else if (emit && rec_done) begin
        busy <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte      <= cur_byte;
      out_last      <= rec_done;
      out_frame_end <= cur_frame_end && !dup_need;
      out_error     <= cur_error;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec <= pop_rec;
    end
  end

`ifndef SYNTHESIS
  a_etx_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_frame_end |-> out_last)
    else $error("frame end byte not marked last");

  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_last && out_byte == '0 && !out_frame_end)
    else $error("error beat malformed");

  a_dup_body_only: assert property (@(posedge clk) disable iff (rst)
    dup |-> busy && (phase == PH_HDR || phase == PH_DATA || phase == PH_CSUM))
    else $error("escape copy outside a body byte");
`endif

endmodule

@@ sv/n2k_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// n2k_frame_encoder: framed byte stream encoder for received CAN messages
// Front classifies items, a record queue decouples it from the byte
// sequencer, which emits the DLE/STX framed, escaped and summed stream.
// ----------------------------------------------------------------------------
// Path: beat, record queue, sequencer state, then the output register.
// Throughput: one output byte per cycle unless the output stalls, set by
//   the single sequencer lane; a header emits 15 bytes plus one per escaped
//   byte, a data item 1 or 2; closing adds 3 to 4 for checksum, DLE, ETX.
// Reset: registers return to default codes, no message open, queue empty.
module n2k_frame_encoder
  import n2kfe_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  n2kfe_in_if.sink             in_ch,
  n2kfe_out_if.source_mp       out_ch
);

  cfg_t cfg;
  logic push_valid;
  logic push_ready;
  rec_t push_rec;
  logic pop_valid;
  logic pop_ready;
  rec_t pop_rec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.command <= RST_COMMAND;
      cfg.dle     <= RST_DLE;
      cfg.esc     <= RST_ESC;
      cfg.stx     <= RST_STX;
      cfg.etx     <= RST_ETX;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COMMAND: cfg.command <= cfg_data;
        REG_DLE:     cfg.dle     <= cfg_data;
        REG_ESC:     cfg.esc     <= cfg_data;
        REG_STX:     cfg.stx     <= cfg_data;
        REG_ETX:     cfg.etx     <= cfg_data;
        default:     ;
      endcase
    end
  end

  n2kfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  n2kfe_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  n2kfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec),
    .out_ch    (out_ch)
  );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the CAN message frame encoder
// A queue-fed driver sends header and data beats with random gaps, a
// monitor compares each output beat against a predicted framed byte stream
// (DLE/STX framing, byte stuffing, sum checksum), across several code sets.
// ----------------------------------------------------------------------------
module tb_top
  import n2kfe_pkg::*;
  ();

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1500000;

  typedef enum bit {
    ACT_HEADER = 1'b0,
    ACT_DATA   = 1'b1
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [PRIO_W-1:0] priority_req;
    logic [PGN_W-1:0]  pgn;
    logic [BYTE_W-1:0] destination;
    logic [BYTE_W-1:0] source;
    logic [TS_W-1:0]   timestamp;
    logic [LEN_W-1:0]  data_len;
    logic [BYTE_W-1:0] data_byte;
  } can_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              frame_end;
    logic              error;
  } stream_beat_t;

  // command, length, priority, pgn x3, destination, source, timestamp x4, length
  typedef logic [12:0][BYTE_W-1:0] hdr_body_t;

  logic clk;
  logic rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  n2kfe_in_if  in_ch ();
  n2kfe_out_if out_ch ();

  n2k_frame_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // stimulus and expected stream
  can_item_t    can_item_q[$];
  stream_beat_t framed_bytes_q[$];

  // encoder shadow state
  cfg_t              codes = '{command: RST_COMMAND, dle: RST_DLE, esc: RST_ESC,
                               stx: RST_STX, etx: RST_ETX};
  logic              msg_open  = 1'b0;
  logic [LEN_W-1:0]  bytes_left = '0;
  logic [BYTE_W-1:0] body_sum_acc = '0;

  int        items_sent = 0;
  int        in_beats   = 0;
  int        in_gap     = 0;
  int        stall_left = 0;
  int        failures   = 0;
  int        cycles     = 0;
  bit        no_idle    = 1'b0;
  can_item_t nxt;
  can_item_t seen;
  stream_beat_t want;

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------- helpers

  // append to the tail of the stimulus and expected-stream queues
  task automatic enqueue_item(can_item_t it);
    can_item_q.insert(can_item_q.size(), it);
  endtask

  task automatic enqueue_beat(stream_beat_t bt);
    framed_bytes_q.insert(framed_bytes_q.size(), bt);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // bias toward the escaped codes so stuffing gets exercised
  function automatic logic [BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return codes.dle;
    if (r < 30) return codes.esc;
    return BYTE_W'($urandom);
  endfunction

  function automatic hdr_body_t header_body(can_item_t it, logic [BYTE_W-1:0] cmd);
    hdr_body_t         b;
    logic [LEN_W-1:0]  n;
    n = (it.data_len > MAX_DATA_LEN) ? LEN_W'(MAX_DATA_LEN) : it.data_len;
    b[0]  = cmd;
    b[1]  = n + BYTE_W'(HDR_LEN_BIAS);
    b[2]  = BYTE_W'(it.priority_req);
    b[3]  = it.pgn[7:0];
    b[4]  = it.pgn[15:8];
    b[5]  = BYTE_W'(it.pgn[PGN_W-1:16]);
    b[6]  = it.destination;
    b[7]  = it.source;
    b[8]  = it.timestamp[7:0];
    b[9]  = it.timestamp[15:8];
    b[10] = it.timestamp[23:16];
    b[11] = it.timestamp[31:24];
    b[12] = n;
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] header_sum(can_item_t it);
    hdr_body_t         b;
    logic [BYTE_W-1:0] s;
    b = header_body(it, codes.command);
    s = '0;
    for (int i = 0; i < 13; i++) s += b[i];
    return s;
  endfunction

  function automatic can_item_t hdr(logic [PRIO_W-1:0] prio, logic [PGN_W-1:0] pgn,
                                    logic [BYTE_W-1:0] dst, logic [BYTE_W-1:0] src,
                                    logic [TS_W-1:0] ts, logic [LEN_W-1:0] len);
    can_item_t m;
    m.action       = ACT_HEADER;
    m.priority_req = prio;
    m.pgn          = pgn;
    m.destination  = dst;
    m.source       = src;
    m.timestamp    = ts;
    m.data_len     = len;
    m.data_byte    = BYTE_W'($urandom);
    return m;
  endfunction

  // header fields carry noise on data beats; the block must ignore them
  function automatic can_item_t dat(logic [BYTE_W-1:0] b);
    can_item_t m;
    m.action       = ACT_DATA;
    m.priority_req = PRIO_W'($urandom);
    m.pgn          = PGN_W'($urandom);
    m.destination  = BYTE_W'($urandom);
    m.source       = BYTE_W'($urandom);
    m.timestamp    = $urandom;
    m.data_len     = LEN_W'($urandom);
    m.data_byte    = b;
    return m;
  endfunction

  // ------------------------------------------------------------- predictor

  task automatic put_raw(logic [BYTE_W-1:0] b, logic fe);
    stream_beat_t bt;
    bt = '{out_byte: b, last: 1'b0, frame_end: fe, error: 1'b0};
    enqueue_beat(bt);
  endtask

  task automatic put_stuffed(logic [BYTE_W-1:0] b);
    if (b == codes.dle || b == codes.esc) put_raw(b, 1'b0);
    put_raw(b, 1'b0);
  endtask

  task automatic put_summed(logic [BYTE_W-1:0] b);
    body_sum_acc += b;
    put_stuffed(b);
  endtask

  task automatic close_frame();
    put_stuffed(BYTE_W'(0) - body_sum_acc);
    put_raw(codes.dle, 1'b0);
    put_raw(codes.etx, 1'b1);
    msg_open     = 1'b0;
    bytes_left   = '0;
    body_sum_acc = '0;
  endtask

  task automatic frame_predict(can_item_t it);
    hdr_body_t    body;
    stream_beat_t tail;
    if (it.action == ACT_DATA && !msg_open) begin
      // data with no message open: single error beat, state untouched
      tail = '{out_byte: '0, last: 1'b1, frame_end: 1'b0, error: 1'b1};
      enqueue_beat(tail);
    end else begin
      if (it.action == ACT_HEADER) begin
        // a header drops any open message silently
        body         = header_body(it, codes.command);
        body_sum_acc = '0;
        put_raw(codes.dle, 1'b0);
        put_raw(codes.stx, 1'b0);
        for (int i = 0; i < 13; i++) put_summed(body[i]);
        msg_open   = 1'b1;
        bytes_left = body[12];
        if (bytes_left == 0) close_frame();
      end else begin
        put_summed(it.data_byte);
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) close_frame();
      end
      tail      = framed_bytes_q.pop_back();
      tail.last = 1'b1;
      enqueue_beat(tail);
    end
  endtask

  // -------------------------------------------------------------- sequences

  task automatic queue_message(logic [LEN_W-1:0] len, int n_data);
    enqueue_item(hdr(PRIO_W'($urandom), PGN_W'($urandom), pick_byte(),
                     pick_byte(), $urandom, len));
    for (int i = 0; i < n_data; i++) enqueue_item(dat(pick_byte()));
  endtask

  // mostly complete frames, some cut short by a new header, some stray data
  task automatic queue_random(int n_items);
    int made;
    int r;
    int len;
    int sat;
    int k;
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        k = $urandom_range(0, 99);
        len = (k < 60) ? $urandom_range(0, 4) :
              (k < 90) ? $urandom_range(5, 16) : $urandom_range(17, 60);
        queue_message(LEN_W'(len), len);
        made += len + 1;
      end else if (r < 85) begin
        len = $urandom_range(0, 255);
        sat = (len > MAX_DATA_LEN) ? MAX_DATA_LEN : len;
        k   = (sat == 0) ? 0 : $urandom_range(0, (sat < 6) ? sat - 1 : 5);
        queue_message(LEN_W'(len), k);
        made += k + 1;
      end else begin
        k = $urandom_range(1, 2);
        for (int i = 0; i < k; i++) enqueue_item(dat(pick_byte()));
        made += k;
      end
    end
  endtask

  // sender holds off until every predicted beat has come out
  task automatic drain_stream();
    while (can_item_q.size() != 0 || in_ch.valid || framed_bytes_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [BYTE_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      REG_COMMAND: codes.command = v;
      REG_DLE:     codes.dle     = v;
      REG_ESC:     codes.esc     = v;
      REG_STX:     codes.stx     = v;
      REG_ETX:     codes.etx     = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_codes(logic [BYTE_W-1:0] cmd, logic [BYTE_W-1:0] dle,
                           logic [BYTE_W-1:0] esc, logic [BYTE_W-1:0] stx,
                           logic [BYTE_W-1:0] etx);
    write_reg(REG_COMMAND, cmd);
    write_reg(REG_DLE, dle);
    write_reg(REG_ESC, esc);
    write_reg(REG_STX, stx);
    write_reg(REG_ETX, etx);
  endtask

  // ----------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (!rst && (!in_ch.valid || in_beats == items_sent)) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (can_item_q.size() != 0) begin
        nxt = can_item_q.pop_front();
        in_ch.action       <= nxt.action;
        in_ch.priority_req <= nxt.priority_req;
        in_ch.pgn          <= nxt.pgn;
        in_ch.destination  <= nxt.destination;
        in_ch.source       <= nxt.source;
        in_ch.timestamp    <= nxt.timestamp;
        in_ch.data_len     <= nxt.data_len;
        in_ch.data_byte    <= nxt.data_byte;
        in_ch.valid        <= 1'b1;
        items_sent         <= items_sent + 1;
        in_gap             <= pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
    end
  end

  // input beat taken: predict its output bytes
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      seen.action       = action_t'(in_ch.action);
      seen.priority_req = in_ch.priority_req;
      seen.pgn          = in_ch.pgn;
      seen.destination  = in_ch.destination;
      seen.source       = in_ch.source;
      seen.timestamp    = in_ch.timestamp;
      seen.data_len     = in_ch.data_len;
      seen.data_byte    = in_ch.data_byte;
      frame_predict(seen);
      in_beats <= in_beats + 1;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (framed_bytes_q.size() == 0) begin
        $error("unexpected output beat: out_byte %0h last %0b frame_end %0b error %0b",
               out_ch.out_byte, out_ch.last, out_ch.frame_end, out_ch.error);
        failures++;
      end else begin
        want = framed_bytes_q.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_ch.out_byte);
          failures++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          failures++;
        end
        if (out_ch.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_ch.frame_end);
          failures++;
        end
        if (out_ch.error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, out_ch.error);
          failures++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- phases

  initial begin
    can_item_t h;
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = REG_COMMAND;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_HEADER;
    in_ch.priority_req = '0;
    in_ch.pgn          = '0;
    in_ch.destination  = '0;
    in_ch.source       = '0;
    in_ch.timestamp    = '0;
    in_ch.data_len     = '0;
    in_ch.data_byte    = '0;
    out_ch.ready       = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed, reset codes
    enqueue_item(dat(8'h5A));                               // no message open
    enqueue_item(hdr('1, '1, '1, '1, '1, 8'd0));            // all ones, empty
    enqueue_item(hdr('0, '0, '0, '0, '0, 8'd0));            // all zeros, empty
    // escape codes inside header fields and payload
    enqueue_item(hdr(3'd5, 18'h10_1B, codes.dle, codes.esc,
                     {codes.esc, codes.dle, codes.esc, codes.dle}, 8'd2));
    enqueue_item(dat(codes.dle));
    enqueue_item(dat(codes.esc));
    // open message dropped by a new header; checksum lands on DLE
    enqueue_item(hdr(3'd1, 18'h2_0100, 8'h01, 8'h02, 32'h0403_0201, 8'd3));
    enqueue_item(dat(8'hFF));
    h = hdr(3'd2, 18'h1_F004, 8'h33, 8'h44, 32'h89AB_CDEF, 8'd1);
    enqueue_item(h);
    enqueue_item(dat(BYTE_W'(0) - codes.dle - header_sum(h)));
    enqueue_item(dat(8'h00));                               // stray after close
    // checksum lands on ESC
    h = hdr(3'd6, 18'h0_EA00, 8'hFF, 8'h00, 32'h0000_FFFF, 8'd1);
    enqueue_item(h);
    enqueue_item(dat(BYTE_W'(0) - codes.esc - header_sum(h)));
    // oversize length saturates; dropped by an empty header
    enqueue_item(hdr(3'd4, 18'h3_0000, 8'h80, 8'h7F, 32'h8000_0000, 8'd255));
    enqueue_item(dat(8'h80));
    enqueue_item(dat(8'h7F));
    enqueue_item(hdr(3'd3, 18'h0_FFFF, 8'hAA, 8'h55, 32'h5555_AAAA, 8'd0));
    enqueue_item(hdr(3'd0, 18'h1_2345, 8'h10, 8'h20, 32'h1234_5678, 8'd1));
    enqueue_item(dat(8'h00));
    enqueue_item(hdr(3'd7, 18'h2_6789, 8'h30, 8'h40, 32'h9ABC_DEF0, 8'd1));
    enqueue_item(dat(8'hFF));
    queue_random(30);
    drain_stream();

    // all codes zero, no idling on either side
    set_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    no_idle = 1'b1;
    queue_random(20);
    drain_stream();
    no_idle = 1'b0;

    // all codes at max
    set_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_random(20);
    drain_stream();

    // DLE equal to ESC, command itself escaped
    h.data_byte = BYTE_W'($urandom);
    set_codes(h.data_byte, h.data_byte, h.data_byte, BYTE_W'($urandom),
              BYTE_W'($urandom));
    queue_random(20);
    drain_stream();

    // random codes; one frame at the largest payload
    set_codes(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
              BYTE_W'($urandom), BYTE_W'($urandom));
    queue_message(LEN_W'($urandom_range(MAX_DATA_LEN + 1, 255)), MAX_DATA_LEN);
    queue_random(20);
    drain_stream();

    if (failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
